// ===== hw/rtl/bma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants of the bump allocator with mark and release.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam int BASE_W     = 48;
  localparam int CAP_W      = 32;
  localparam int BYTES_W    = 32;
  localparam int ALIGN_W    = 17;
  localparam int MASK_W     = 16;
  localparam int MARK_W     = 32;
  localparam int CNT_W      = 64;
  localparam int OPC_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 336;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 32'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_CAPACITY = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESET   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_REJECT     = 2'd1,
    ST_MARK_RANGE = 2'd2
  } status_t;

  // classified command as held in the queue
  typedef struct packed {
    opcode_t             opcode;
    logic                bad_req;
    logic [MASK_W-1:0]   align_mask;
    logic [BYTES_W-1:0]  bytes;
    logic [MARK_W-1:0]   mark;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [BASE_W-1:0]   block_address;
    logic [CAP_W-1:0]    used_bytes;
    logic [CAP_W-1:0]    remaining_bytes;
    logic [CAP_W-1:0]    peak_bytes;
    logic [CNT_W-1:0]    allocation_count;
    logic [CNT_W-1:0]    rejection_count;
    logic [CNT_W-1:0]    reset_count;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bma_front
// Accepts request items, checks size and alignment, and pushes commands.
// ----------------------------------------------------------------------------
module bma_front
  import bma_pkg::*;
(
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [OPC_W-1:0]      s_axis_tuser,
  input  wire logic                  queue_full,
  output logic                       push,
  output cmd_t                       cmd
);

  logic [BYTES_W-1:0] req_bytes;
  logic [ALIGN_W-1:0] req_align;
  logic [ALIGN_W-1:0] align_dec;
  logic               align_pow2;

  assign req_bytes = s_axis_tdata[BYTES_W-1:0];
  assign req_align = s_axis_tdata[BYTES_W +: ALIGN_W];
  assign align_dec = req_align - ALIGN_W'(1);
  // zero alignment fails the pow2 test as well
  assign align_pow2 = (req_align != '0) && ((req_align & align_dec) == '0);

  assign s_axis_tready = !queue_full && !rst;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.opcode     = opcode_t'(s_axis_tuser);
    cmd.bad_req    = (req_bytes == '0) || !align_pow2;
    cmd.align_mask = align_dec[MASK_W-1:0];
    cmd.bytes      = req_bytes;
    cmd.mark       = s_axis_tdata[BYTES_W+ALIGN_W +: MARK_W];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bma_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bma_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bma_queue
  import bma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bma_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bma_back
// Executes commands against the offset, peak and counters; holds the
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module bma_back
  import bma_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   head_valid,
  input  cmd_t                        head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output result_t                     result
);

  // wide enough for offset plus padding plus size without overflow
  localparam int WIDE_W = ((OFFSET_BITS > CAP_W) ? OFFSET_BITS : CAP_W) + 2;

  logic [BASE_W-1:0]       base_address;
  logic [CAP_W-1:0]        region_capacity;

  logic [OFFSET_BITS-1:0]  used_offset, used_offset_next;
  logic [OFFSET_BITS-1:0]  peak_offset, peak_offset_next;
  logic [CNT_W-1:0]        granted_total, granted_total_next;
  logic [CNT_W-1:0]        refused_total, refused_total_next;
  logic [CNT_W-1:0]        reset_total, reset_total_next;
  result_t                 result_next;

  logic [WIDE_W-1:0]       ofs_max_w;
  logic [WIDE_W-1:0]       cap_w;
  logic [WIDE_W-1:0]       used_w;
  logic [WIDE_W-1:0]       aligned_w;
  logic [WIDE_W-1:0]       end_w;
  logic [WIDE_W-1:0]       mark_w;
  logic [WIDE_W-1:0]       used_next_w;
  logic [MASK_W-1:0]       addr_lo;
  logic [MASK_W-1:0]       pad;
  logic                    fits;
  logic [BASE_W-1:0]       grant_addr;

  assign pop = head_valid && (!out_valid || out_ready);

  assign ofs_max_w = WIDE_W'({OFFSET_BITS{1'b1}});
  assign cap_w     = (WIDE_W'(region_capacity) > ofs_max_w) ? ofs_max_w
                                                             : WIDE_W'(region_capacity);
  assign used_w    = WIDE_W'(used_offset);
  assign mark_w    = WIDE_W'(head.mark);

  // padding up to the alignment depends only on the low address bits
  assign addr_lo    = base_address[MASK_W-1:0] + used_w[MASK_W-1:0];
  assign pad        = (~addr_lo + MASK_W'(1)) & head.align_mask;
  assign aligned_w  = used_w + WIDE_W'(pad);
  assign end_w      = aligned_w + WIDE_W'(head.bytes);
  assign fits       = (end_w <= cap_w);
  assign grant_addr = base_address + BASE_W'(aligned_w);

  always_comb begin
    used_offset_next   = used_offset;
    peak_offset_next   = peak_offset;
    granted_total_next = granted_total;
    refused_total_next = refused_total;
    reset_total_next   = reset_total;
    result_next.status        = ST_OK;
    result_next.block_address = '0;
    case (head.opcode)
      OP_ALLOC: begin
        if (head.bad_req || !fits) begin
          result_next.status = ST_REJECT;
          refused_total_next = refused_total + CNT_W'(1);
        end else begin
          used_offset_next   = OFFSET_BITS'(end_w);
          if (OFFSET_BITS'(end_w) > peak_offset) begin
            peak_offset_next = OFFSET_BITS'(end_w);
          end
          granted_total_next        = granted_total + CNT_W'(1);
          result_next.block_address = grant_addr;
        end
      end
      OP_RESET: begin
        used_offset_next = '0;
        reset_total_next = reset_total + CNT_W'(1);
      end
      OP_RELEASE: begin
        if (mark_w > used_w) begin
          result_next.status = ST_MARK_RANGE;
        end else begin
          used_offset_next = OFFSET_BITS'(mark_w);
        end
      end
      default: begin
      end
    endcase
    used_next_w                  = WIDE_W'(used_offset_next);
    result_next.used_bytes       = CAP_W'(used_next_w);
    result_next.remaining_bytes  = (used_next_w >= cap_w) ? '0
                                                          : CAP_W'(cap_w - used_next_w);
    result_next.peak_bytes       = CAP_W'(WIDE_W'(peak_offset_next));
    result_next.allocation_count = granted_total_next;
    result_next.rejection_count  = refused_total_next;
    result_next.reset_count      = reset_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= '0;
      region_capacity <= CAPACITY_RESET;
      used_offset     <= '0;
      peak_offset     <= '0;
      granted_total   <= '0;
      refused_total   <= '0;
      reset_total     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BASE_ADDRESS:    base_address    <= cfg_data[BASE_W-1:0];
          CFG_REGION_CAPACITY: region_capacity <= cfg_data[CAP_W-1:0];
          default: begin
          end
        endcase
      end
      if (pop) begin
        used_offset   <= used_offset_next;
        peak_offset   <= peak_offset_next;
        granted_total <= granted_total_next;
        refused_total <= refused_total_next;
        reset_total   <= reset_total_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_peak_covers_used: assert property (@(posedge clk) disable iff (rst)
    used_offset <= peak_offset)
    else $error("used offset above peak");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("executed command left no result");

  a_reset_rewinds: assert property (@(posedge clk) disable iff (rst)
    (pop && head.opcode == OP_RESET) |=>
      (used_offset == '0 && reset_total == $past(reset_total) + CNT_W'(1)))
    else $error("reset op did not rewind and count");

  a_release_sets_mark: assert property (@(posedge clk) disable iff (rst)
    (pop && head.opcode == OP_RELEASE && mark_w <= used_w) |=>
      (result.status == ST_OK && result.used_bytes == $past(head.mark)))
    else $error("release did not rewind to mark");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bump_allocator_with_mark_release.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bump_allocator_with_mark_release
// Bump-pointer allocator with mark release and usage statistics.
//
// Request items arrive on the s_axis channel (operation in tuser) and each
// produces exactly one result item on the m_axis channel (status in tuser).
// Configuration (base address, capacity) is written through cfg_wr_en,
// cfg_index and cfg_data; the user must write it only while no item is in
// flight, which the block itself does not enforce. An accepted item is
// written to the command queue and, once it pops, its result to the output
// register. Throughput: one item per cycle while results are taken; the
// offset update (pad, add size, compare with capacity) is combinational in
// the execute stage. Reset: offset, peak and counters clear, base address
// goes to zero and capacity to 65536; items are accepted once reset drops.
// When m_axis_tready is low the result register holds, the two-entry
// queue fills, and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module bump_allocator_with_mark_release
  import bma_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // request_bytes[31:0], request_alignment[48:32], release_mark[80:49], zeros
  input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  wire logic [OPC_W-1:0]       s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // block_address[47:0], used_bytes[79:48], remaining_bytes[111:80],
  // peak_bytes[143:112], allocation_count[207:144], rejection_count[271:208],
  // reset_count[335:272]
  output logic [M_TDATA_W-1:0]        m_axis_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]           m_axis_tuser
);

  logic    queue_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  logic    head_valid;
  cmd_t    head;
  result_t result;

  bma_front u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  bma_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bma_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .result     (result)
  );

  assign m_axis_tuser = result.status;
  assign m_axis_tdata = {result.reset_count,
                         result.rejection_count,
                         result.allocation_count,
                         result.peak_bytes,
                         result.remaining_bytes,
                         result.used_bytes,
                         result.block_address};

endmodule
`default_nettype wire

// ===== tb/tb_bump_allocator_with_mark_release.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bump_allocator_with_mark_release
// Self-checking bench for the bump allocator. Request items go in on the
// s_axis side and each one is run through a local model of the arena
// (offset, peak, three wrapping counters, base and capacity). The model's
// outcome is queued and compared field by field with every result item on
// the m_axis side. Directed cases cover the operations, bad sizes and
// alignments, overflow, address wrap and capacity shrink. Random traffic
// follows under several configurations and idle/stall mixes, then a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_bump_allocator_with_mark_release;
  import bma_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // request_bytes[31:0], request_alignment[48:32], release_mark[80:49], zeros
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // opcode[1:0]
  logic [OPC_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // block_address[47:0], used_bytes[79:48], remaining_bytes[111:80],
  // peak_bytes[143:112], allocation_count[207:144], rejection_count[271:208],
  // reset_count[335:272]
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // status[1:0]
  logic [STAT_W-1:0]     m_axis_tuser;

  bump_allocator_with_mark_release uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // arena model state
  logic [BASE_W-1:0] arena_base = '0;
  logic [CAP_W-1:0]  arena_cap  = CAPACITY_RESET;
  logic [31:0]       used_off   = '0;
  logic [31:0]       peak_off   = '0;
  logic [CNT_W-1:0]  grants     = '0;
  logic [CNT_W-1:0]  refusals   = '0;
  logic [CNT_W-1:0]  resets_seen = '0;

  result_t pending_results[$];

  int   error_count = 0;
  int   cycle_count = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic start_hold = 1'b0;
  int   hold_left = 0;

  // advance the arena by one request and return what the block should answer
  function automatic result_t apply_request(input opcode_t op, input logic [31:0] nbytes,
                                            input logic [16:0] align,
                                            input logic [31:0] mark);
    result_t     r;
    logic [63:0] amask, abs_addr, up, aligned, cap64, nxt;
    r = '0;
    r.status = ST_OK;
    cap64 = {32'b0, arena_cap};
    case (op)
      OP_ALLOC: begin
        if (nbytes == 0 || align == 0 || (align & (align - 17'd1)) != 0) begin
          r.status = ST_REJECT;
        end else begin
          amask    = {47'b0, align} - 64'd1;
          abs_addr = {16'b0, arena_base} + {32'b0, used_off};
          up       = (abs_addr + amask) & ~amask;
          aligned  = up - {16'b0, arena_base};
          if (aligned > cap64 || {32'b0, nbytes} > cap64 - aligned) begin
            r.status = ST_REJECT;
          end else begin
            nxt = aligned + {32'b0, nbytes};
            used_off = nxt[31:0];
            if (nxt[31:0] > peak_off) peak_off = nxt[31:0];
            grants = grants + 1;
            r.block_address = arena_base + aligned[47:0];
          end
        end
        if (r.status == ST_REJECT) refusals = refusals + 1;
      end
      OP_RESET: begin
        used_off = '0;
        resets_seen = resets_seen + 1;
      end
      OP_RELEASE: begin
        if (mark > used_off) r.status = ST_MARK_RANGE;
        else used_off = mark;
      end
      default: ;
    endcase
    r.used_bytes       = used_off;
    r.remaining_bytes  = (used_off >= arena_cap) ? '0 : arena_cap - used_off;
    r.peak_bytes       = peak_off;
    r.allocation_count = grants;
    r.rejection_count  = refusals;
    r.reset_count      = resets_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result item with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    check_field("status", m_axis_tuser, want.status);
    check_field("block_address", m_axis_tdata[47:0], want.block_address);
    check_field("used_bytes", m_axis_tdata[79:48], want.used_bytes);
    check_field("remaining_bytes", m_axis_tdata[111:80], want.remaining_bytes);
    check_field("peak_bytes", m_axis_tdata[143:112], want.peak_bytes);
    check_field("allocation_count", m_axis_tdata[207:144], want.allocation_count);
    check_field("rejection_count", m_axis_tdata[271:208], want.rejection_count);
    check_field("reset_count", m_axis_tdata[335:272], want.reset_count);
  endtask

  // result side: check accepted items, drive tready with stalls and hold-off
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    if (start_hold) begin
      start_hold = 1'b0;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** bump_allocator_with_mark_release: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input opcode_t op, input logic [31:0] nbytes,
                           input logic [16:0] align, input logic [31:0] mark);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, mark, align, nbytes};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_request(op, nbytes, align, mark));
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) arena_base = value;
    else arena_cap = value[31:0];
    @(posedge clk);
  endtask

  // mostly well-formed requests, with sizes scaled to the capacity
  task automatic send_random_item();
    opcode_t     op;
    logic [31:0] nbytes, mark, span;
    logic [16:0] align;
    int          r;
    r = $urandom_range(99);
    if (r < 55) op = OP_ALLOC;
    else if (r < 75) op = OP_RELEASE;
    else if (r < 87) op = OP_RESET;
    else op = OP_QUERY;
    span = arena_cap >> 4;
    if (span > 4096) span = 4096;
    if (span == 0) span = 1;
    case ($urandom_range(15))
      0:       nbytes = '0;
      1:       nbytes = $urandom;
      2, 3:    nbytes = $urandom_range(arena_cap, 1);
      default: nbytes = $urandom_range(span, 1);
    endcase
    case ($urandom_range(19))
      0:       align = '0;
      1:       align = 17'($urandom_range(17'h1FFFF));
      2, 3:    align = 17'd1 << $urandom_range(16);
      default: align = 17'd1 << $urandom_range(6);
    endcase
    case ($urandom_range(9))
      0:       mark = $urandom;
      1:       mark = used_off + 1;
      2:       mark = used_off;
      default: mark = $urandom_range(used_off, 0);
    endcase
    send_item(op, nbytes, align, mark);
  endtask

  task automatic test_operations();
    send_item(OP_QUERY, 32'd0, 17'd0, 32'd0);
    send_item(OP_ALLOC, 32'd1, 17'd1, 32'd0);
    send_item(OP_ALLOC, 32'd0, 17'd1, 32'd0);
    send_item(OP_ALLOC, 32'd8, 17'd0, 32'd0);
    send_item(OP_ALLOC, 32'd8, 17'h1FFFF, 32'd0);
    // aligned offset lands exactly on capacity, no room left
    send_item(OP_ALLOC, 32'd16, 17'd65536, 32'd0);
    send_item(OP_ALLOC, 32'd16, 17'd16, 32'd0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 17'd1, 32'd0);
    send_item(OP_RELEASE, 32'd0, 17'd0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'd0, 17'd0, used_off + 1);
    send_item(OP_RELEASE, 32'd0, 17'd0, 32'd1);
    send_item(OP_RESET, 32'd0, 17'd0, 32'd0);
    send_item(OP_ALLOC, 32'd65536, 17'd1, 32'd0);
    send_item(OP_ALLOC, 32'd1, 17'd1, 32'd0);
    send_item(OP_RELEASE, 32'd0, 17'd0, used_off);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // base at the top of the address space, block address wraps
    write_reg(CFG_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_REGION_CAPACITY, 48'hFFFF_FFFF);
    send_item(OP_RESET, 32'd0, 17'd0, 32'd0);
    send_item(OP_ALLOC, 32'd100, 17'd65536, 32'd0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 17'd1, 32'd0);
    wait_idle();
    write_reg(CFG_BASE_ADDRESS, 48'd0);
    write_reg(CFG_REGION_CAPACITY, 48'd1);
    send_item(OP_RESET, 32'd0, 17'd0, 32'd0);
    send_item(OP_ALLOC, 32'd1, 17'd1, 32'd0);
    send_item(OP_ALLOC, 32'd1, 17'd1, 32'd0);
    wait_idle();
    // capacity shrunk under the current offset
    write_reg(CFG_BASE_ADDRESS, 48'h1235);
    write_reg(CFG_REGION_CAPACITY, 48'd65536);
    send_item(OP_ALLOC, 32'd4000, 17'd64, 32'd0);
    wait_idle();
    write_reg(CFG_REGION_CAPACITY, 48'd100);
    send_item(OP_ALLOC, 32'd1, 17'd1, 32'd0);
    send_item(OP_RELEASE, 32'd0, 17'd0, 32'd50);
    send_item(OP_ALLOC, 32'd8, 17'd8, 32'd0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;
          write_reg(CFG_BASE_ADDRESS, 48'd0);
          write_reg(CFG_REGION_CAPACITY, 48'hFFFF_FFFF);
        end
        1: begin
          src_idle_pct = 67; sink_stall_pct = 0;
          write_reg(CFG_BASE_ADDRESS, 48'({$urandom, $urandom}));
          write_reg(CFG_REGION_CAPACITY, 48'($urandom_range(8192, 256)));
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 67;
          write_reg(CFG_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF);
          write_reg(CFG_REGION_CAPACITY, 48'($urandom_range(4096, 1)));
        end
        default: begin
          src_idle_pct = 8;  sink_stall_pct = 8;
          write_reg(CFG_BASE_ADDRESS, 48'({$urandom, $urandom}));
          write_reg(CFG_REGION_CAPACITY, 48'($urandom_range(32'hFFFF_FFFF, 1)));
        end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_reg(CFG_REGION_CAPACITY, 48'd2048);
    start_hold = 1'b1;
    // keeps offering while results are held off, the queue fills up
    repeat (24) send_random_item();
    wait_idle();
    repeat (8) send_random_item();
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_operations();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** bump_allocator_with_mark_release: PASSED **");
    end else begin
      $display("** bump_allocator_with_mark_release: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bma_pkg.sv
hw/rtl/bma_front.sv
hw/rtl/bma_queue.sv
hw/rtl/bma_back.sv
hw/rtl/bump_allocator_with_mark_release.sv
tb/tb_bump_allocator_with_mark_release.sv
